// File: rtl/swept_multitap_delay_reverb_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the swept multitap delay reverb core.
// Shared concurrent assertion forms used by the RTL.
// ----------------------------------------------------------------------------
`ifndef SWEPT_MULTITAP_DELAY_REVERB_CORE_ASSERT_SVH
`define SWEPT_MULTITAP_DELAY_REVERB_CORE_ASSERT_SVH

// Implication checked every clock outside reset.
`define SMDR_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked every clock outside reset.
`define SMDR_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/smdr_pkg.sv
// ----------------------------------------------------------------------------
// smdr_pkg
// Constants and helpers for the swept multitap delay reverb core.
// ----------------------------------------------------------------------------
package smdr_pkg;

	localparam int MAX_TAPS = 30;

	localparam logic [31:0] LEAK_RESET   = 32'd16760439;
	localparam logic [31:0] DECAY_Q24    = 32'd16775538;
	localparam logic [31:0] LEAK_STEP    = 32'd1099512;
	localparam logic [31:0] HUNDRED_Q24  = 32'd1677721600;

	// configuration register indexes
	localparam logic [2:0] REG_STEP_PERIOD = 3'd0;
	localparam logic [2:0] REG_DEPTH_MIN   = 3'd1;
	localparam logic [2:0] REG_DEPTH_MAX   = 3'd2;
	localparam logic [2:0] REG_OUT_GAIN    = 3'd3;
	localparam logic [2:0] REG_WET_MIX     = 3'd4;

	// prime multiplier of each tap
	function automatic logic [6:0] prime_of(input logic [4:0] t);
		logic [6:0] p;
		begin
			case (t)
				5'd0: p = 7'd2;    5'd1: p = 7'd3;    5'd2: p = 7'd5;
				5'd3: p = 7'd7;    5'd4: p = 7'd11;   5'd5: p = 7'd13;
				5'd6: p = 7'd17;   5'd7: p = 7'd19;   5'd8: p = 7'd23;
				5'd9: p = 7'd29;   5'd10: p = 7'd31;  5'd11: p = 7'd37;
				5'd12: p = 7'd41;  5'd13: p = 7'd43;  5'd14: p = 7'd47;
				5'd15: p = 7'd53;  5'd16: p = 7'd59;  5'd17: p = 7'd61;
				5'd18: p = 7'd67;  5'd19: p = 7'd71;  5'd20: p = 7'd73;
				5'd21: p = 7'd79;  5'd22: p = 7'd83;  5'd23: p = 7'd89;
				5'd24: p = 7'd97;  5'd25: p = 7'd101; 5'd26: p = 7'd103;
				5'd27: p = 7'd107; 5'd28: p = 7'd109; 5'd29: p = 7'd113;
				default: p = 7'd2;
			endcase
			return p;
		end
	endfunction

	// round to nearest (ties up) then shift right, for a 64-bit signed value
	function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
			input int unsigned s);
		logic signed [63:0] w;
		begin
			w = v + (64'sd1 <<< (s - 1));
			return w >>> s;
		end
	endfunction

	// saturate to 32 signed
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		begin
			if (v > 64'sd2147483647) return 32'sh7fffffff;
			else if (v < -64'sd2147483648) return 32'sh80000000;
			else return v[31:0];
		end
	endfunction

endpackage

// File: rtl/swept_multitap_delay_reverb_core.sv
// ----------------------------------------------------------------------------
// swept_multitap_delay_reverb_core
// Sample-by-sample swept multitap delay reverb with leaky accumulator.
// ----------------------------------------------------------------------------
// The delay memory has one read port, so the taps are read one per cycle and
// each pair also passes the shared leak multiplier; the tap move and leak
// update (MOVE, LEAK1, LEAK2) come before the taps and the gain and mix
// (OUT1, OUT2, OUT3) after them. A new word is taken only once the last one
// has reached the output register, and OUT3 waits while that register still
// holds an untaken result. After reset the delay memory is cleared to zero,
// word by word, before the first word is taken. The next word is accepted
// while the previous result waits in the output register.
module swept_multitap_delay_reverb_core
	import smdr_pkg::*;
#(
	parameter int DELAY_DEPTH = 16384,
	parameter int TAP_COUNT   = 30
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [23:0] sample_in
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [23:0] sample_out
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [16:0] cfg_data
);

`include "swept_multitap_delay_reverb_core_assert.svh"

	localparam int AW = $clog2(DELAY_DEPTH);
	localparam int TW = 5;
	localparam int PAIRS = TAP_COUNT / 2;
	localparam logic [AW-1:0] TOP = AW'(DELAY_DEPTH - 1);
	localparam logic [TW-1:0] LAST_TAP = TW'(TAP_COUNT - 1);

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_MOVE  = 4'd2;
	localparam logic [3:0] ST_LEAK1 = 4'd3;
	localparam logic [3:0] ST_LEAK2 = 4'd4;
	localparam logic [3:0] ST_MUL   = 4'd5;
	localparam logic [3:0] ST_SUB   = 4'd6;
	localparam logic [3:0] ST_ADD   = 4'd7;
	localparam logic [3:0] ST_OUT1  = 4'd8;
	localparam logic [3:0] ST_OUT2  = 4'd9;
	localparam logic [3:0] ST_OUT3  = 4'd10;

	// configuration registers
	logic [9:0]  step_period_q;
	logic [15:0] depth_min_q, depth_max_q, gain_q;
	logic [16:0] wet_q;

	// write configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_period_q <= 10'd10;
			depth_min_q   <= 16'd9000;
			depth_max_q   <= 16'd18000;
			gain_q        <= 16'd3277;
			wet_q         <= 17'd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STEP_PERIOD: step_period_q <= cfg_data[9:0];
				REG_DEPTH_MIN:   depth_min_q   <= cfg_data[15:0];
				REG_DEPTH_MAX:   depth_max_q   <= cfg_data[15:0];
				REG_OUT_GAIN:    gain_q        <= cfg_data[15:0];
				REG_WET_MIX:     wet_q         <= cfg_data;
				default: ;
			endcase
		end
	end

	// state
	logic [3:0]  state_q;
	logic [AW-1:0] clr_q, wp_q;
	logic [AW-1:0] tap_off_q [TAP_COUNT];
	logic [TAP_COUNT-1:0] up_q;
	logic [9:0]  pc_q;
	logic [TW-1:0] turn_q;
	logic        move_q;
	logic signed [31:0] acc_q, leak_q, a_q;
	logic signed [63:0] prod_q;
	logic signed [23:0] x_q;
	logic [TW-1:0] k_q;
	logic signed [23:0] rd_q;
	logic [23:0] out_q;
	logic        out_v_q;

	// delay memory
	logic signed [23:0] mem [DELAY_DEPTH];
	logic        mem_we;
	logic [AW-1:0] mem_wa, mem_ra;
	logic signed [23:0] mem_wd;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_q <= mem[mem_ra];
	end

	// tap address: write pointer plus offset, wrapped
	function automatic logic [AW-1:0] tap_addr(input logic [AW-1:0] wp,
			input logic [AW-1:0] off);
		logic [AW:0] s;
		begin
			s = {1'b0, wp} + {1'b0, off};
			if (s >= (AW+1)'(DELAY_DEPTH)) s = s - (AW+1)'(DELAY_DEPTH);
			if (s >= (AW+1)'(DELAY_DEPTH)) s = '0;
			return s[AW-1:0];
		end
	endfunction

	// tap bound: prime * depth / 256, clamped
	function automatic logic [AW-1:0] bound(input logic [6:0] p, input logic [15:0] d);
		logic [22:0] m;
		logic [15:0] b;
		begin
			m = 23'(p) * 23'(d);
			b = 16'(m[22:8]);
			if (32'(b) > DELAY_DEPTH - 1) return TOP;
			return b[AW-1:0];
		end
	endfunction

	logic [TW-1:0] tap_rd;
	logic [TW-1:0] nturn;
	logic s_acc;
	logic signed [63:0] tapv;
	logic [9:0] period;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc = s_tvalid && s_tready;
	assign nturn = (turn_q == LAST_TAP) ? '0 : turn_q + 1'b1;
	assign tapv = 64'(rd_q) * 2;
	assign period = (step_period_q > 10'd1000) ? 10'd1000 : step_period_q;

	// address the odd tap in MUL, the even one in SUB
	always_comb begin
		tap_rd = (state_q == ST_SUB) ? TW'({k_q, 1'b0}) : TW'({k_q, 1'b1});
		mem_ra = tap_addr(wp_q, tap_off_q[tap_rd]);
		mem_we = 1'b0;
		mem_wa = wp_q;
		mem_wd = 24'(signed'(s_tdata));
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
			mem_wd = '0;
		end else if (s_acc) begin
			mem_we = 1'b1;
		end
	end

	logic signed [31:0] pmove;
	logic [AW-1:0] lo_b, hi_b;
	logic signed [32:0] acc_w;
	logic [32:0] magv;

	assign lo_b = bound(prime_of(turn_q), depth_min_q);
	assign hi_b = bound(prime_of(turn_q), depth_max_q);
	assign pmove = 32'(tap_off_q[turn_q]) + (up_q[turn_q] ? 32'sd1 : -32'sd1);
	assign acc_w = 33'(acc_q);
	assign magv = acc_w[32] ? 33'(-acc_w) : 33'(acc_w);

	// clamp the moved tap: lower bound first, then upper bound
	logic signed [31:0] pclamp;
	logic [AW-1:0] pnew;
	logic pup;

	always_comb begin
		pclamp = pmove;
		pup = up_q[turn_q];
		if (pmove < signed'(32'(lo_b))) begin
			pclamp = signed'(32'(lo_b));
			pup = 1'b1;
		end
		if (pclamp > signed'(32'(hi_b))) begin
			pclamp = signed'(32'(hi_b));
			pup = 1'b0;
		end
		pnew = pclamp[AW-1:0];
	end

	logic [16:0] wv;
	logic signed [63:0] yv;
	logic out_load;
	assign wv = wet_q > 17'd65536 ? 17'd65536 : wet_q;
	assign yv = rnd_shr(prod_q, 1);
	assign out_load = (state_q == ST_OUT3) && (!out_v_q || m_tready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			wp_q    <= '0;
			for (int i = 0; i < TAP_COUNT; i++) tap_off_q[i] <= AW'(1);
			up_q    <= '1;
			pc_q    <= '0;
			turn_q  <= '0;
			move_q  <= 1'b0;
			acc_q   <= '0;
			leak_q  <= LEAK_RESET;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == TOP) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (s_acc) begin
						x_q <= s_tdata;
						state_q <= ST_MOVE;
					end
				end
				ST_MOVE: begin
					// step one tap once the sample count exceeds the period
					move_q <= (pc_q > period);
					if (pc_q > period) begin
						pc_q <= '0;
						turn_q <= nturn;
					end
					state_q <= ST_LEAK1;
				end
				ST_LEAK1: begin
					if (move_q) begin
						tap_off_q[turn_q] <= pnew;
						up_q[turn_q] <= pup;
					end
					prod_q <= 64'(leak_q) * 64'(DECAY_Q24);
					state_q <= ST_LEAK2;
				end
				ST_LEAK2: begin
					leak_q <= sat32(rnd_shr(prod_q, 24) + rnd_shr(
						(64'(HUNDRED_Q24) - 64'(magv)) * 64'(LEAK_STEP), 40));
					a_q <= acc_q;
					k_q <= TW'(PAIRS - 1);
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					prod_q <= 64'(a_q) * 64'(leak_q);
					state_q <= ST_SUB;
				end
				ST_SUB: begin
					a_q <= sat32(64'(sat32(rnd_shr(prod_q, 24))) - tapv);
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					a_q <= sat32(64'(a_q) + tapv);
					if (k_q == '0) state_q <= ST_OUT1;
					else begin
						k_q <= k_q - 1'b1;
						prod_q <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_OUT1: begin
					acc_q <= a_q;
					wp_q <= (wp_q == '0) ? TOP : wp_q - 1'b1;
					pc_q <= pc_q + 1'b1;
					prod_q <= rnd_shr(64'(a_q) * 64'(gain_q), 16);
					state_q <= ST_OUT2;
				end
				ST_OUT2: begin
					prod_q <= rnd_shr(64'(x_q) * 2 * 64'(17'd65536 - wv)
						+ prod_q * 64'(wv), 16);
					state_q <= ST_OUT3;
				end
				ST_OUT3: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// load the saturated result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			out_q   <= '0;
		end else if (out_load) begin
			if (yv > 64'sd8388607) out_q <= 24'h7fffff;
			else if (yv < -64'sd8388608) out_q <= 24'h800000;
			else out_q <= yv[23:0];
			out_v_q <= 1'b1;
		end else if (out_v_q && m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

	`SMDR_ASSERT_IMP(a_no_accept_busy, s_acc, state_q == ST_IDLE, "accept while busy")
	`SMDR_ASSERT_NXT(a_acc_starts, s_acc, state_q == ST_MOVE, "accept did not start work")
	`SMDR_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
		"result dropped")

endmodule

// File: tb/swept_multitap_delay_reverb_core_test.sv
// ----------------------------------------------------------------------------
// Swept multitap delay reverb core testbench
// Streams audio words through the core under a series of register settings,
// predicts every output word with an independent model of the tap sweep,
// leaky accumulator and wet/dry mix, and checks each one as it leaves.
// ----------------------------------------------------------------------------
module swept_multitap_delay_reverb_core_test;
	import smdr_pkg::*;

	localparam int DEPTH      = 16384;
	localparam int TAPS       = 30;
	localparam int STALL_MAX  = 13;
	localparam int QUIET_MAX  = 40000;
	localparam int DRY_FIRST  = 12;
	localparam int ROWS       = 20;
	localparam int PHASES     = 10;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [23:0] m_tdata;
	logic        cfg_we    = 1'b0;
	logic [2:0]  cfg_index = REG_STEP_PERIOD;
	logic [16:0] cfg_data  = '0;

	swept_multitap_delay_reverb_core DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// reverb predictor state
	// ------------------------------------------------------------------
	int unsigned tap_prime [TAPS] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43,
		47, 53, 59, 61, 67, 71, 73, 79, 83, 89, 97, 101, 103, 107, 109, 113};
	logic signed [23:0] echo_line [DEPTH];
	int unsigned        head_ptr;
	int                 tap_pos [TAPS];
	bit                 tap_rising [TAPS];
	int unsigned        beat_cnt;
	int unsigned        tap_sel;
	longint             acc_q;
	longint             leak_q;
	int unsigned        period_r, dmin_r, dmax_r, gain_r, wet_r;

	logic [23:0] out_due [$];
	int          mismatches = 0;
	int          words_in = 0;
	int          words_out = 0;
	bit          calm = 1'b0;

	// floor(v / 2^s) after adding half an LSB
	function automatic longint half_up_shift(longint v, int s);
		longint biased;
		biased = v + (longint'(1) << (s - 1));
		return biased >>> s;
	endfunction

	function automatic longint clip_q824(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic int sweep_bound(int unsigned prime, int unsigned unit);
		int unsigned b;
		b = (prime * unit) >> 8;
		if (b > DEPTH - 1)
			b = DEPTH - 1;
		return int'(b);
	endfunction

	function automatic longint tap_word(int t);
		int unsigned idx;
		idx = head_ptr + tap_pos[t];
		if (idx >= DEPTH)
			idx -= DEPTH;
		if (idx >= DEPTH)
			idx = 0;
		return longint'(echo_line[idx]) * 2;
	endfunction

	task automatic reset_reverb();
		period_r = 10; dmin_r = 9000; dmax_r = 18000; gain_r = 3277; wet_r = 65536;
		foreach (echo_line[i]) echo_line[i] = '0;
		foreach (tap_pos[i]) begin
			tap_pos[i] = 1;
			tap_rising[i] = 1'b1;
		end
		head_ptr = 0; beat_cnt = 0; tap_sel = 0; acc_q = 0;
		leak_q = longint'(LEAK_RESET);
	endtask

	// advance the reverb by one sample and return the output word
	function automatic logic [23:0] reverb_sample(logic [23:0] din);
		longint x, a, mag, y, mix, o;
		int unsigned per, w;
		int lo, hi, p;
		x = longint'($signed(din));
		per = period_r > 1000 ? 1000 : period_r;
		w = wet_r > 65536 ? 65536 : wet_r;
		echo_line[head_ptr] = din;
		// sweep the next tap in turn
		if (beat_cnt > per) begin
			beat_cnt = 0;
			tap_sel = (tap_sel + 1 >= TAPS) ? 0 : tap_sel + 1;
			lo = sweep_bound(tap_prime[tap_sel], dmin_r);
			hi = sweep_bound(tap_prime[tap_sel], dmax_r);
			p = tap_pos[tap_sel] + (tap_rising[tap_sel] ? 1 : -1);
			if (p < lo) begin
				p = lo;
				tap_rising[tap_sel] = 1'b1;
			end
			if (p > hi) begin
				p = hi;
				tap_rising[tap_sel] = 1'b0;
			end
			tap_pos[tap_sel] = p;
		end
		// adapt the leak from the previous accumulator
		a = acc_q;
		mag = a < 0 ? -a : a;
		leak_q = clip_q824(half_up_shift(leak_q * longint'(DECAY_Q24), 24) +
			half_up_shift((longint'(HUNDRED_Q24) - mag) * longint'(LEAK_STEP), 40));
		for (int k = TAPS / 2 - 1; k >= 0; k--) begin
			a = clip_q824(half_up_shift(a * leak_q, 24));
			a = clip_q824(a - tap_word(2 * k + 1));
			a = clip_q824(a + tap_word(2 * k));
		end
		acc_q = a;
		head_ptr = head_ptr == 0 ? DEPTH - 1 : head_ptr - 1;
		beat_cnt = (beat_cnt + 1) & 10'h3FF;
		// gain, wet/dry mix, back to Q1.23
		y = half_up_shift(a * longint'(gain_r), 16);
		mix = half_up_shift(x * 2 * longint'(65536 - w) + y * longint'(w), 16);
		o = half_up_shift(mix, 1);
		if (o > 8388607)
			o = 8388607;
		if (o < -8388608)
			o = -8388608;
		return o[23:0];
	endfunction

	// ------------------------------------------------------------------
	// configuration
	// ------------------------------------------------------------------
	task automatic write_reg(logic [2:0] idx, logic [16:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_STEP_PERIOD: period_r = val & 17'h3FF;
			REG_DEPTH_MIN:   dmin_r = val & 17'hFFFF;
			REG_DEPTH_MAX:   dmax_r = val & 17'hFFFF;
			REG_OUT_GAIN:    gain_r = val & 17'hFFFF;
			REG_WET_MIX:     wet_r = val;
			default: ;
		endcase
	endtask

	task automatic drain();
		wait (out_due.size() == 0);
		repeat (80) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// sender
	// ------------------------------------------------------------------
	task automatic send_word(logic [23:0] din, bit known, logic [23:0] want);
		int gap;
		gap = calm ? 0 : $urandom_range(0, STALL_MAX);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= din;
		do @(posedge clk); while (!s_tready);
		want = known ? want : reverb_sample(din);
		if (known)
			void'(reverb_sample(din));
		out_due.push_back(want);
		words_in++;
	endtask

	function automatic logic [23:0] random_sample();
		case ($urandom_range(0, 9))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return 24'($signed($urandom_range(0, 511)) - 256);
			default: return 24'($urandom);
		endcase
	endfunction

	// ------------------------------------------------------------------
	// receiver and checker
	// ------------------------------------------------------------------
	int rx_hold = 0;
	logic [23:0] want_word;

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			words_out++;
			if (out_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output word %h", m_tdata);
			end else begin
				want_word = out_due.pop_front();
				if (m_tdata !== want_word) begin
					mismatches++;
					if (mismatches <= 10)
						$display("sample_out mismatch at word %0d: expected %h got %h",
							words_out, want_word, m_tdata);
				end
			end
			rx_hold = calm ? 0 : $urandom_range(0, STALL_MAX);
			if (rx_hold > 0)
				m_tready <= 1'b0;
		end else if (rx_hold > 0) begin
			rx_hold--;
			if (rx_hold == 0)
				m_tready <= 1'b1;
		end else if (arst_n) begin
			m_tready <= 1'b1;
		end
	end

	// abort when nothing moves for too long (covers the memory clear)
	int quiet = 0;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet = 0;
		else if (++quiet >= QUIET_MAX) begin
			$display("timeout: no word moved for %0d cycles", QUIET_MAX);
			$display("FAIL swept_multitap_delay_reverb_core");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	typedef struct {
		logic [23:0] din;
		bit          known;
		logic [23:0] want;
	} vec_row_t;

	// first row: empty line and zero accumulator give silence when fully wet;
	// rows from DRY_FIRST run with the mix fully dry, so output equals input
	vec_row_t vec_rows [ROWS] = '{
		'{24'h7FFFFF, 1'b1, 24'h000000},
		'{24'h800000, 1'b0, 24'h0},
		'{24'h000000, 1'b0, 24'h0},
		'{24'hFFFFFF, 1'b0, 24'h0},
		'{24'h000001, 1'b0, 24'h0},
		'{24'h7FFFFF, 1'b0, 24'h0},
		'{24'h7FFFFF, 1'b0, 24'h0},
		'{24'h800000, 1'b0, 24'h0},
		'{24'h800000, 1'b0, 24'h0},
		'{24'h555555, 1'b0, 24'hAAAAAA},
		'{24'hAAAAAA, 1'b0, 24'h0},
		'{24'h123456, 1'b0, 24'h0},
		'{24'h7FFFFF, 1'b1, 24'h7FFFFF},
		'{24'h800000, 1'b1, 24'h800000},
		'{24'h000000, 1'b1, 24'h000000},
		'{24'hFFFFFF, 1'b1, 24'hFFFFFF},
		'{24'h000001, 1'b1, 24'h000001},
		'{24'h555555, 1'b1, 24'h555555},
		'{24'hAAAAAA, 1'b1, 24'hAAAAAA},
		'{24'h400000, 1'b1, 24'h400000}
	};

	initial begin
		int n;
		reset_reverb();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed words
		for (int i = 0; i < ROWS; i++) begin
			if (i == DRY_FIRST) begin
				s_tvalid <= 1'b0;
				drain();
				write_reg(REG_WET_MIX, 17'd0);
				cfg_we <= 1'b0;
			end
			send_word(vec_rows[i].din, vec_rows[i].known, vec_rows[i].want);
		end
		s_tvalid <= 1'b0;

		// random phases, each under its own register setting
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			calm = (ph == 3 || ph == 7);
			case (ph)
				// fast sweep inside narrow bounds so taps bounce often
				0: begin
					write_reg(REG_STEP_PERIOD, 17'd0);
					write_reg(REG_DEPTH_MIN, 17'd0);
					write_reg(REG_DEPTH_MAX, 17'd512);
					write_reg(REG_OUT_GAIN, 17'd65535);
					write_reg(REG_WET_MIX, 17'd65536);
				end
				// period and mix beyond range, bounds beyond the line for the larger primes
				1: begin
					write_reg(REG_STEP_PERIOD, 17'd1023);
					write_reg(REG_DEPTH_MIN, 17'd65535);
					write_reg(REG_DEPTH_MAX, 17'd65535);
					write_reg(REG_OUT_GAIN, 17'd0);
					write_reg(REG_WET_MIX, 17'h1FFFF);
				end
				// lower bound above upper
				2: begin
					write_reg(REG_STEP_PERIOD, 17'd0);
					write_reg(REG_DEPTH_MIN, 17'd36224);
					write_reg(REG_DEPTH_MAX, 17'd512);
					write_reg(REG_OUT_GAIN, 17'd40000);
					write_reg(REG_WET_MIX, 17'd32768);
				end
				3: begin
					write_reg(REG_STEP_PERIOD, 17'd1000);
					write_reg(REG_DEPTH_MIN, 17'd36224);
					write_reg(REG_DEPTH_MAX, 17'd36224);
					write_reg(REG_OUT_GAIN, 17'd65535);
					write_reg(REG_WET_MIX, 17'd1);
				end
				default: begin
					write_reg(REG_STEP_PERIOD, 17'($urandom_range(0, 3)));
					write_reg(REG_DEPTH_MIN, 17'($urandom_range(0, 2000)));
					write_reg(REG_DEPTH_MAX, 17'($urandom_range(512, 3000)));
					write_reg(REG_OUT_GAIN, 17'($urandom_range(0, 65535)));
					write_reg(REG_WET_MIX, 17'($urandom_range(0, 65536)));
				end
			endcase
			cfg_we <= 1'b0;
			n = $urandom_range(90, 110);
			for (int i = 0; i < n; i++)
				send_word(random_sample(), 1'b0, 24'h0);
			s_tvalid <= 1'b0;
		end

		// let the last words drain
		wait (out_due.size() == 0);
		repeat (100) @(posedge clk);
		$display("%0d words sent and %0d checked over %0d register settings,",
			words_in, words_out, PHASES + 2);
		$display("including fast sweeps, out-of-range settings and crossed bounds");
		if (mismatches == 0 && out_due.size() == 0) begin
			$display("PASS swept_multitap_delay_reverb_core");
		end else begin
			$display("%0d mismatches, %0d words still expected", mismatches, out_due.size());
			$display("FAIL swept_multitap_delay_reverb_core");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/smdr_pkg.sv
rtl/swept_multitap_delay_reverb_core.sv
tb/swept_multitap_delay_reverb_core_test.sv
